// ===== design/ctcw_pkg.sv =====
package ctcw_pkg;
  localparam int unsigned CompactW = 32;
  localparam int unsigned WideW = 256;
  localparam int unsigned WordW = 64;
  localparam int unsigned IdxW = 2;
  localparam int unsigned NumWords = WideW / WordW;
  localparam int unsigned StepW = $clog2(WideW);
  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic [WideW-1:0] target;
    logic             invalid;
  } job_t;

  typedef enum logic [1:0] {
    BkIdle,
    BkDiv,
    BkInc,
    BkOut
  } back_state_e;
endpackage

// ===== design/ctcw_front.sv =====
module ctcw_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [ctcw_pkg::CompactW-1:0]    compact_bits_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  output ctcw_pkg::job_t                   job_o,
  output logic                             job_valid_o,
  input  logic                             job_ready_i
);
  import ctcw_pkg::*;

  logic [7:0]       size;
  logic [22:0]      mant;
  logic             neg, ovf, mant_nz;
  logic [WideW-1:0] tgt;
  logic [8:0]       shamt;
  job_t             job_q;
  logic             vld_q;

  assign size    = compact_bits_i[31:24];
  assign mant    = compact_bits_i[22:0];
  assign mant_nz = (mant != '0);
  assign neg     = mant_nz && compact_bits_i[23];
  assign ovf     = mant_nz && ((size > 8'd34) || ((mant > 23'hff) && (size > 8'd33)) ||
                               ((mant > 23'hffff) && (size > 8'd32)));
  assign shamt   = 9'({size, 3'b000} - 11'd24);

  always_comb begin
    tgt = '0;
    if (size <= 8'd3) begin
      tgt = WideW'(mant >> {(2'd3 - size[1:0]), 3'b000});
    end else if (size < 8'd35) begin
      tgt = WideW'(mant) << shamt;
    end
  end

  assign in_ready_o  = !vld_q || job_ready_i;
  assign job_o       = job_q;
  assign job_valid_o = vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      job_q.target  <= tgt;
      job_q.invalid <= neg || ovf || (tgt == '0);
    end
  end
endmodule

// ===== design/ctcw_queue.sv =====
module ctcw_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ctcw_pkg::job_t wr_job_i,
  input  logic           wr_valid_i,
  output logic           wr_ready_o,
  output ctcw_pkg::job_t rd_job_o,
  output logic           rd_valid_o,
  input  logic           rd_ready_i
);
  import ctcw_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  job_t          mem_q [QueueDepth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [PtrW:0]   cnt_q;
  logic            wr, rd;

  assign wr_ready_o = (cnt_q != (PtrW+1)'(QueueDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_job_o   = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= wp_q + 1'b1;
      if (rd) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(wr) - (PtrW+1)'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_job_i;
  end
endmodule

// ===== design/ctcw_back.sv =====
module ctcw_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ctcw_pkg::job_t                job_i,
  input  logic                          job_valid_i,
  output logic                          job_ready_o,
  output logic [ctcw_pkg::WordW-1:0]    work_word_o,
  output logic [ctcw_pkg::IdxW-1:0]     word_index_o,
  output logic                          last_word_o,
  output logic                          target_invalid_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i
);
  import ctcw_pkg::*;

  back_state_e      state_q, state_d;
  logic [WideW-1:0] num_q, den_q, rem_q, quo_q;
  logic             inv_q;
  logic [StepW-1:0] step_q;
  logic [IdxW-1:0]  idx_q;
  logic [WideW:0]   rsh, diff;
  logic             take;

  // remainder shifted by one with next dividend bit
  assign rsh  = {rem_q, num_q[WideW-1]};
  assign diff = rsh - {1'b0, den_q};
  assign take = !diff[WideW];

  assign job_ready_o      = (state_q == BkIdle);
  assign out_valid_o      = (state_q == BkOut);
  assign work_word_o      = quo_q[WordW-1:0];
  assign word_index_o     = idx_q;
  assign last_word_o      = (idx_q == IdxW'(NumWords - 1));
  assign target_invalid_o = inv_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BkIdle: if (job_valid_i) state_d = job_i.invalid ? BkOut : BkDiv;
      BkDiv:  if (step_q == '1) state_d = BkInc;
      BkInc:  state_d = BkOut;
      BkOut:  if (out_ready_i && last_word_o) state_d = BkIdle;
      default: state_d = BkIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BkIdle;
      step_q  <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == BkIdle) begin
        step_q <= '0;
        idx_q  <= '0;
      end else if (state_q == BkDiv) begin
        step_q <= step_q + 1'b1;
      end else if (state_q == BkOut && out_ready_i) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      BkIdle: begin
        num_q <= ~job_i.target;
        den_q <= job_i.target + 1'b1;
        rem_q <= '0;
        quo_q <= '0;
        inv_q <= job_i.invalid;
      end
      BkDiv: begin
        num_q <= num_q << 1;
        rem_q <= take ? diff[WideW-1:0] : rsh[WideW-1:0];
        quo_q <= {quo_q[WideW-2:0], take};
      end
      BkInc: quo_q <= quo_q + 1'b1;
      BkOut: if (out_ready_i) quo_q <= quo_q >> WordW;
      default: ;
    endcase
  end
endmodule

// ===== design/compact_target_chain_work.sv =====
// an input passes the front register and the queue; the back end then runs the
// radix-2 restoring divider doing one quotient bit per cycle over 256 bits, then an
// increment and 4 output word transfers, and takes no new job until the last word is
// transferred; invalid targets skip the divider and the increment
// a two-entry queue lets the front accept items while the divider is busy
// reset: asynchronous active-low, clears all control state and the queue count and pointers
module compact_target_chain_work (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [ctcw_pkg::CompactW-1:0] compact_bits_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  output logic [ctcw_pkg::WordW-1:0]    work_word_o,
  output logic [ctcw_pkg::IdxW-1:0]     word_index_o,
  output logic                          last_word_o,
  output logic                          target_invalid_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i
);
  import ctcw_pkg::*;

  job_t f_job, q_job;
  logic f_vld, f_rdy, q_vld, q_rdy;

  ctcw_front u_front (
    .clk_i, .rst_ni, .compact_bits_i, .in_valid_i, .in_ready_o,
    .job_o(f_job), .job_valid_o(f_vld), .job_ready_i(f_rdy)
  );

  ctcw_queue u_queue (
    .clk_i, .rst_ni,
    .wr_job_i(f_job), .wr_valid_i(f_vld), .wr_ready_o(f_rdy),
    .rd_job_o(q_job), .rd_valid_o(q_vld), .rd_ready_i(q_rdy)
  );

  ctcw_back u_back (
    .clk_i, .rst_ni,
    .job_i(q_job), .job_valid_i(q_vld), .job_ready_o(q_rdy),
    .work_word_o, .word_index_o, .last_word_o, .target_invalid_o,
    .out_valid_o, .out_ready_i
  );
endmodule

// ===== sim/work_checker.sv =====
`timescale 1ns / 1ps
module work_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] compact_bits_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [63:0] work_word_i,
  input  logic [1:0]  word_index_i,
  input  logic        last_word_i,
  input  logic        target_invalid_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  output int          fail_count_o,
  output int          pending_o
);
  typedef struct {
    logic [63:0] word;
    logic [1:0]  idx;
    logic        last;
    logic        invalid;
  } slice_t;

  localparam int unsigned SlotN = 4096;

  slice_t      exp_slots [SlotN];
  int unsigned wr_cnt = 0;
  int unsigned rd_cnt = 0;
  int          fails = 0;

  assign fail_count_o = fails;
  assign pending_o    = int'(wr_cnt - rd_cnt);

  // expand compact word and compute 2^256 / (target + 1)
  task automatic predict_work(input logic [31:0] c);
    logic [7:0]   size;
    logic [22:0]  mant;
    logic         neg, ovf, invalid;
    logic [255:0] tgt, num, den, quo, rem;
    logic         carry;
    slice_t       s;
    size = c[31:24];
    mant = c[22:0];
    neg = (mant != 0) && c[23];
    ovf = (mant != 0) && (size > 34 || (mant > 23'hff && size > 33) ||
                          (mant > 23'hffff && size > 32));
    if (size <= 3) tgt = 256'(mant) >> (8 * (3 - size));
    else if (8 * (int'(size) - 3) >= 256) tgt = '0;
    else tgt = 256'(mant) << (8 * (size - 3));
    invalid = neg || ovf || (tgt == 0);
    quo = '0;
    if (!invalid) begin
      num = ~tgt;
      den = tgt + 1;
      rem = '0;
      for (int i = 255; i >= 0; i--) begin
        carry = rem[255];
        rem = {rem[254:0], num[i]};
        if (carry || rem >= den) begin
          rem = rem - den;
          quo[i] = 1'b1;
        end
      end
      quo = quo + 1;
    end
    for (int k = 0; k < 4; k++) begin
      s.word = quo[64*k +: 64];
      s.idx = 2'(k);
      s.last = (k == 3);
      s.invalid = invalid;
      exp_slots[12'(wr_cnt)] = s;
      wr_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_i) predict_work(compact_bits_i);
    if (rst_ni && out_valid_i && out_ready_i) begin
      if (wr_cnt == rd_cnt) begin
        fails++;
        if (fails <= 10) $display("unexpected output transfer idx %0d", word_index_i);
      end else begin
        slice_t e;
        e = exp_slots[12'(rd_cnt)];
        rd_cnt++;
        if (e.word !== work_word_i || e.idx !== word_index_i || e.last !== last_word_i ||
            e.invalid !== target_invalid_i) begin
          fails++;
          if (fails <= 10)
            $display("exp %h idx %0d last %b inv %b, got %h idx %0d last %b inv %b",
                     e.word, e.idx, e.last, e.invalid, work_word_i, word_index_i,
                     last_word_i, target_invalid_i);
        end
      end
    end
  end
endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic [31:0] compact_bits;
  logic        in_valid = 0;
  logic        in_ready;
  logic [63:0] work_word;
  logic [1:0]  word_index;
  logic        last_word, target_invalid, out_valid;
  logic        out_ready = 0;
  int          fail_count, pending;
  int          send_idle = 0, recv_stall = 0;
  logic        hold_start = 0;
  logic        hold = 0;
  longint      cycles = 0;

  always #2 clk_i = ~clk_i;

  compact_target_chain_work i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .compact_bits_i(compact_bits), .in_valid_i(in_valid),
    .in_ready_o(in_ready), .work_word_o(work_word), .word_index_o(word_index),
    .last_word_o(last_word), .target_invalid_o(target_invalid), .out_valid_o(out_valid),
    .out_ready_i(out_ready)
  );

  work_checker i_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .compact_bits_i(compact_bits), .in_valid_i(in_valid),
    .in_ready_i(in_ready), .work_word_i(work_word), .word_index_i(word_index),
    .last_word_i(last_word), .target_invalid_i(target_invalid), .out_valid_i(out_valid),
    .out_ready_i(out_ready), .fail_count_o(fail_count), .pending_o(pending)
  );

  // long receiver hold-off, counted in cycles
  initial begin
    wait (hold_start);
    hold = 1'b1;
    repeat (3000) @(negedge clk_i);
    hold = 1'b0;
  end

  // receiver: random stalls plus one long hold-off
  always @(negedge clk_i) begin
    if (hold) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_item(input logic [31:0] c);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    compact_bits <= c;
    in_valid <= 1'b1;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_compact();
    logic [31:0] c;
    c = $urandom;
    case ($urandom_range(3))
      0: c[31:24] = 8'($urandom_range(0, 40));
      1: begin
        c[31:24] = 8'($urandom_range(3, 32));
        c[23] = 1'b0;
      end
      2: c[23] = 1'b0;
      default: ;
    endcase
    return c;
  endfunction

  logic [31:0] directed[] = '{
    32'h1d00ffff, 32'h00000000, 32'hffffffff, 32'h00800000, 32'h04800000, 32'h04923456,
    32'h01003456, 32'h02008000, 32'h03123456, 32'h01123456, 32'h0100007f, 32'h2200ffff,
    32'h220000ff, 32'h21ffffff, 32'h210000ff, 32'h2000ffff, 32'h20ffffff, 32'h23000001,
    32'h22000100, 32'h2300ff00, 32'h2100ffff, 32'h207fffff, 32'h04000001, 32'h227fffff,
    32'hff7fffff
  };

  initial begin
    compact_bits = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    foreach (directed[i]) send_item(directed[i]);
    // block fills up while output is held off
    hold_start = 1'b1;
    repeat (5) send_item(rand_compact());
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1 || ph == 3) ? (ph == 1 ? 78 : 35) : 0;
      recv_stall = (ph == 2 || ph == 3) ? (ph == 2 ? 78 : 35) : 0;
      repeat (113) send_item(rand_compact());
    end
    in_valid <= 1'b0;
    send_idle = 0;
    recv_stall = 0;
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (fail_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
